// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the flow statistics RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CHK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CHK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// ===== rtl/fccs_pkg.sv =====
// Types and constants for the per-flow congestion-control statistics table.
// No dependencies; used by the interfaces, controller, datapath and top level.
package fccs_pkg;

  localparam int FLOW_ID_W = 10;
  localparam int RTT_SHIFT = 9;
  localparam int RTT_MAX   = 100000;
  localparam int SAMPLE_W  = 14;
  localparam logic [SAMPLE_W-1:0] RTT_SAMPLE_CAP = SAMPLE_W'(RTT_MAX >> 3);

  typedef enum logic [1:0] {
    REQ_ACK  = 2'd0,
    REQ_RETX = 2'd1,
    REQ_TX   = 2'd2,
    REQ_INIT = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t              req_type;
    logic [FLOW_ID_W-1:0]   flow_id;
    logic [31:0]            acked_bytes;
    logic                   has_ack_desc;
    logic                   ecn_marked;
    logic                   retx_mark;
    logic                   pending_clear;
    logic [31:0]            ts_echo;
    logic [31:0]            now_ts;
    logic [31:0]            init_rate;
  } req_t;

  typedef struct packed {
    logic [FLOW_ID_W-1:0]   out_flow;
    logic [31:0]            ack_count;
    logic [63:0]            ack_byte_count;
    logic [63:0]            ecn_byte_count;
    logic [31:0]            drop_count;
    logic                   tx_pending;
    logic [31:0]            rate_interval;
    logic [31:0]            rtt_estimate;
  } rsp_t;

  typedef struct packed {
    logic load_req;
    logic rd;
    logic wr;
  } cmd_t;

endpackage

// ===== rtl/fccs_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on fccs_pkg for the payload types.
interface fccs_req_if;
  import fccs_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fccs_rsp_if;
  import fccs_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/fccs_ctrl.sv =====
// Controller: sequences accept, table read and write-back for each beat.
// Depends on fccs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fccs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output fccs_pkg::cmd_t cmd
);
  import fccs_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    READ,
    WRITE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   accept;

  always_comb begin
    out_free     = !out_valid || out_ready;
    in_ready     = (state == IDLE) || ((state == WRITE) && out_free);
    accept       = in_valid && in_ready;
    cmd.load_req = accept;
    cmd.rd       = (state == READ);
    cmd.wr       = (state == WRITE) && out_free;
    state_next   = state;
    case (state)
      IDLE: begin
        if (accept) state_next = READ;
      end
      READ: begin
        state_next = WRITE;
      end
      WRITE: begin
        if (out_free) state_next = accept ? READ : IDLE;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.wr) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_CHK(a_accept_then_read, clk, rst, accept |=> (state == READ), "accept not followed by read")
  `ASSERT_CHK(a_read_then_write, clk, rst, cmd.rd |=> (state == WRITE), "read not followed by write")
  `ASSERT_CHK(a_write_loads_out, clk, rst, cmd.wr |=> out_valid, "write-back did not present a result")
  `ASSERT_NEVER(a_no_accept_in_read, clk, rst, in_ready && (state == READ), "ready during table read")

endmodule

// ===== rtl/fccs_datapath.sv =====
// Datapath: request register, flow index reduction, entry table and update logic.
// Depends on fccs_pkg; driven by commands from fccs_ctrl.
module fccs_datapath #(
  parameter int FLOW_COUNT = 1024
) (
  input  logic           clk,
  input  fccs_pkg::cmd_t cmd,
  input  fccs_pkg::req_t req_data,
  output fccs_pkg::rsp_t rsp_data
);
  import fccs_pkg::*;

  localparam int IDX_W = (FLOW_COUNT > 1) ? $clog2(FLOW_COUNT) : 1;
  localparam int RECIP = (1 << FLOW_ID_W) / FLOW_COUNT;

  typedef struct packed {
    logic [31:0] ack_cnt;
    logic [63:0] ack_bytes;
    logic [63:0] ecn_bytes;
    logic [31:0] drop_cnt;
    logic        pending;
    logic [31:0] rate;
    logic [31:0] rtt;
  } ent_t;

  ent_t                 mem [FLOW_COUNT];
  req_t                 req;
  logic [FLOW_ID_W-1:0] quot;
  logic [FLOW_ID_W-1:0] quot_next;
  logic [FLOW_ID_W-1:0] rem_raw;
  logic [FLOW_ID_W-1:0] rem;
  logic [IDX_W-1:0]     idx_rd;
  logic [IDX_W-1:0]     idx;
  ent_t                 rd_ent;
  ent_t                 upd;
  logic [31:0]          rate_dbl;
  logic [31:0]          delta;
  logic [31:0]          sample_raw;
  logic [SAMPLE_W-1:0]  sample;
  logic [32:0]          est_sum;
  logic [31:0]          est_next;

  // Quotient by reciprocal, may fall one short; fix up with one subtract.
  always_comb begin
    quot_next = FLOW_ID_W'((32'(req_data.flow_id) * RECIP) >> FLOW_ID_W);
    rem_raw   = req.flow_id - FLOW_ID_W'(32'(quot) * FLOW_COUNT);
    if (32'(rem_raw) >= 32'(FLOW_COUNT)) begin
      rem = rem_raw - FLOW_ID_W'(FLOW_COUNT);
    end else begin
      rem = rem_raw;
    end
    idx_rd = IDX_W'(rem);
  end

  always_comb begin
    rate_dbl   = rd_ent.rate[31] ? 32'hFFFF_FFFF : {rd_ent.rate[30:0], 1'b0};
    delta      = req.now_ts - req.ts_echo;
    sample_raw = delta >> RTT_SHIFT;
    sample     = (sample_raw > 32'(RTT_SAMPLE_CAP)) ? RTT_SAMPLE_CAP : sample_raw[SAMPLE_W-1:0];
    est_sum    = {1'b0, rd_ent.rtt} + 33'(sample) - 33'(rd_ent.rtt >> 3);
    est_next   = est_sum[32] ? 32'hFFFF_FFFF : est_sum[31:0];
    upd        = rd_ent;
    case (req.req_type)
      REQ_ACK: begin
        upd.ack_cnt = rd_ent.ack_cnt + 32'd1;
        if (req.has_ack_desc) begin
          upd.ack_bytes = rd_ent.ack_bytes + 64'(req.acked_bytes);
          if (req.ecn_marked) upd.ecn_bytes = rd_ent.ecn_bytes + 64'(req.acked_bytes);
        end
        if (req.retx_mark) begin
          upd.drop_cnt = rd_ent.drop_cnt + 32'd1;
          upd.pending  = 1'b0;
          upd.rate     = rate_dbl;
        end
        if (req.pending_clear) upd.pending = 1'b0;
        if (req.ts_echo != 32'd0) upd.rtt = est_next;
      end
      REQ_RETX: begin
        upd.drop_cnt = rd_ent.drop_cnt + 32'd1;
        upd.pending  = 1'b0;
        upd.rate     = rate_dbl;
      end
      REQ_TX: begin
        upd.pending = 1'b1;
      end
      REQ_INIT: begin
        upd      = '0;
        upd.rate = req.init_rate;
      end
      default: begin
        upd = rd_ent;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req  <= req_data;
      quot <= quot_next;
    end
    if (cmd.rd) begin
      idx    <= idx_rd;
      rd_ent <= mem[idx_rd];
    end
    if (cmd.wr) begin
      mem[idx]                <= upd;
      rsp_data.out_flow       <= req.flow_id;
      rsp_data.ack_count      <= upd.ack_cnt;
      rsp_data.ack_byte_count <= upd.ack_bytes;
      rsp_data.ecn_byte_count <= upd.ecn_bytes;
      rsp_data.drop_count     <= upd.drop_cnt;
      rsp_data.tx_pending     <= upd.pending;
      rsp_data.rate_interval  <= upd.rate;
      rsp_data.rtt_estimate   <= upd.rtt;
    end
  end

endmodule

// ===== rtl/flow_cc_stats_update_top.sv =====
// Each request beat is registered when taken; its entry is read (registered) in READ and the
// updated entry is written back, with the result registered, in WRITE. A new beat is taken in
//   WRITE, as read and write-back alternate on the single-port entry table; a held result stalls both.
// Reset clears the controller and the result valid; table contents stay
//   undefined until a flow sees an init event. No clearing pass is run.
module flow_cc_stats_update_top #(
  parameter int FLOW_COUNT = 1024
) (
  input logic       clk,
  input logic       rst,
  fccs_req_if.sink  req,
  fccs_rsp_if.source rsp
);
  import fccs_pkg::*;

  cmd_t cmd;

  fccs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  fccs_datapath #(
    .FLOW_COUNT (FLOW_COUNT)
  ) u_datapath (
    .clk      (clk),
    .cmd      (cmd),
    .req_data (req.data),
    .rsp_data (rsp.data)
  );

endmodule
